### rtl/cea_pkg.sv
// shared constants for the coalescing extent allocator
`timescale 1ns / 1ps
`default_nettype none
package cea_pkg;

	localparam int HEAP_BYTES_DEF  = 1024 * 128;
	localparam int QUANTUM_DEF     = 16;
	localparam int MAX_EXTENTS_DEF = 64;

	localparam int FUNC_W  = 1;
	localparam int ADDR_W  = 17;
	localparam int LEN_W   = 18;
	localparam int STAT_W  = 2;

	localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

endpackage
`default_nettype wire

### rtl/coalescing_extent_allocator.sv
// coalescing worst-fit extent allocator, top level
//
//  channel | handshake           | word fields
//  in      | valid ready         | func block_address length_bytes
//  out     | out_valid out_ready | status granted_address largest_free
//
// one request at a time; the extent table sits in one memory with registered reads
// every table pass (merge scan, delete shift, insert scan and shift) reads an entry, then acts on it
// each merge adds a delete shift and a rescan of the table from the first entry
// after reset the init state writes the whole-heap extent before the first request is taken
// a new request waits until the previous result word has been taken
`timescale 1ns / 1ps
`default_nettype none
module coalescing_extent_allocator import cea_pkg::*; #(
	parameter int HEAP_BYTES  = HEAP_BYTES_DEF,
	parameter int QUANTUM     = QUANTUM_DEF,
	parameter int MAX_EXTENTS = MAX_EXTENTS_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                valid,
	output logic               ready,
	input  wire  [FUNC_W-1:0]  func,
	input  wire  [ADDR_W-1:0]  block_address,
	input  wire  [LEN_W-1:0]   length_bytes,
	output logic               out_valid,
	input  wire                out_ready,
	output logic [STAT_W-1:0]  status,
	output logic [ADDR_W-1:0]  granted_address,
	output logic [LEN_W-1:0]   largest_free
);

	localparam int IW = $clog2(MAX_EXTENTS);
	localparam int CW = $clog2(MAX_EXTENTS + 1);
	localparam int HW = $clog2(HEAP_BYTES + 1) + 1;
	localparam int VW = (HW > LEN_W + 1) ? HW : LEN_W + 1;
	localparam logic [VW-1:0] HEAP_V = VW'(HEAP_BYTES);
	localparam logic [VW-1:0] QMASK  = VW'(QUANTUM - 1);

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_HEAD, S_DEL, S_MSCAN, S_ISCAN, S_ISHIFT, S_IWR,
		S_FIN_RD, S_FIN
	} state_t;

	// extent table memory, start and size packed in one word
	logic [2*VW-1:0] mem [MAX_EXTENTS];
	logic [2*VW-1:0] rd_q;
	logic [IW-1:0]   raddr;
	logic            we;
	logic [IW-1:0]   waddr;
	logic [2*VW-1:0] wdata;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic [CW-1:0]     pos_q;
	logic              ph_q;
	logic              merging_q;
	logic [VW-1:0]     len_q;
	logic [VW-1:0]     start_q, size_q;
	logic [STAT_W-1:0] stat_q;
	logic [ADDR_W-1:0] grant_q;
	logic [LEN_W-1:0]  largest_q;

	logic [VW-1:0] rd_start, rd_size;
	assign rd_start = rd_q[2*VW-1:VW];
	assign rd_size  = rd_q[VW-1:0];

	// rounded length and room left up to the heap end
	logic [VW-1:0] len_rnd;
	logic [VW-1:0] addr_v;
	logic [VW-1:0] room;
	assign len_rnd = (VW'(length_bytes) + QMASK) & ~QMASK;
	assign addr_v  = VW'(block_address);
	assign room    = HEAP_V - addr_v;

	assign ready = (state_q == S_IDLE) && !out_valid;

	// read address: scans read idx, delete reads idx+1, shift reads idx-1, else head
	always_comb begin
		raddr = '0;
		if (state_q == S_DEL) raddr = IW'(idx_q + CW'(1));
		else if (state_q == S_MSCAN || state_q == S_ISCAN) raddr = idx_q[IW-1:0];
		else if (state_q == S_ISHIFT) raddr = IW'(idx_q - CW'(1));
	end

	// table writes: initial extent, shifted entries, inserted extent
	always_comb begin
		we    = 1'b0;
		waddr = pos_q[IW-1:0];
		wdata = {start_q, size_q};
		if (state_q == S_INIT) begin
			we    = 1'b1;
			waddr = '0;
			wdata = {VW'(0), HEAP_V};
		end else if ((state_q == S_DEL || state_q == S_ISHIFT) && ph_q) begin
			we    = 1'b1;
			waddr = idx_q[IW-1:0];
			wdata = rd_q;
		end else if (state_q == S_IWR) begin
			we = 1'b1;
		end
	end

	// sequencer: remove head, merge passes, ordered insert
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			count_q   <= CW'(1);
			idx_q     <= '0;
			pos_q     <= '0;
			ph_q      <= 1'b0;
			merging_q <= 1'b0;
			len_q     <= '0;
			start_q   <= '0;
			size_q    <= '0;
			out_valid <= 1'b0;
			stat_q    <= ST_OK;
			grant_q   <= '0;
			largest_q <= '0;
		end else begin
			// result word handshake
			if (state_q == S_FIN) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;

			unique case (state_q)
				S_INIT: state_q <= S_IDLE;
				S_IDLE: begin
					if (valid && ready) begin
						len_q   <= len_rnd;
						grant_q <= '0;
						idx_q   <= '0;
						ph_q    <= 1'b0;
						stat_q  <= (func == FUNC_ALLOC && count_q == '0) ? ST_NOFIT : ST_OK;
						if (func == FUNC_ALLOC) begin
							if (count_q == '0) state_q <= S_FIN_RD;
							else state_q <= S_HEAD;
						end else if (len_rnd == '0 || addr_v >= HEAP_V) begin
							state_q <= S_FIN_RD;
						end else begin
							start_q <= addr_v;
							size_q  <= (len_rnd > room) ? room : len_rnd;
							state_q <= S_MSCAN;
						end
					end
				end
				// head entry is in rd_q; if it fits, grant it and delete it
				S_HEAD: begin
					if (rd_size < len_q) begin
						stat_q  <= ST_NOFIT;
						state_q <= S_FIN_RD;
					end else begin
						grant_q   <= ADDR_W'(rd_start);
						start_q   <= rd_start + len_q;
						size_q    <= rd_size - len_q;
						merging_q <= 1'b0;
						idx_q     <= '0;
						ph_q      <= 1'b0;
						state_q   <= S_DEL;
					end
				end
				// close the gap at idx by moving later entries down
				S_DEL: begin
					if (!ph_q) begin
						if (idx_q + CW'(1) >= count_q) begin
							count_q <= count_q - CW'(1);
							idx_q   <= '0;
							if (merging_q || size_q != '0) state_q <= S_MSCAN;
							else state_q <= S_FIN_RD;
						end else ph_q <= 1'b1;
					end else begin
						ph_q  <= 1'b0;
						idx_q <= idx_q + CW'(1);
					end
				end
				// merge scan: read then compare each entry, restart from the first after each merge
				S_MSCAN: begin
					if (!ph_q) begin
						if (idx_q >= count_q) begin
							idx_q <= '0;
							if (count_q >= CW'(MAX_EXTENTS)) begin
								stat_q  <= ST_FULL;
								state_q <= S_FIN_RD;
							end else state_q <= S_ISCAN;
						end else ph_q <= 1'b1;
					end else begin
						ph_q <= 1'b0;
						if (start_q + size_q == rd_start) begin
							size_q    <= size_q + rd_size;
							merging_q <= 1'b1;
							state_q   <= S_DEL;
						end else if (rd_start + rd_size == start_q) begin
							start_q   <= rd_start;
							size_q    <= size_q + rd_size;
							merging_q <= 1'b1;
							state_q   <= S_DEL;
						end else idx_q <= idx_q + CW'(1);
					end
				end
				// find insert position: first entry not larger
				S_ISCAN: begin
					if (!ph_q) begin
						if (idx_q >= count_q) begin
							pos_q   <= idx_q;
							state_q <= S_ISHIFT;
						end else ph_q <= 1'b1;
					end else begin
						ph_q <= 1'b0;
						if (rd_size > size_q) idx_q <= idx_q + CW'(1);
						else begin
							pos_q   <= idx_q;
							idx_q   <= count_q;
							state_q <= S_ISHIFT;
						end
					end
				end
				// open a hole at the insert position from the top down
				S_ISHIFT: begin
					if (!ph_q) begin
						if (idx_q == pos_q) state_q <= S_IWR;
						else ph_q <= 1'b1;
					end else begin
						ph_q  <= 1'b0;
						idx_q <= idx_q - CW'(1);
					end
				end
				S_IWR: begin
					count_q <= count_q + CW'(1);
					state_q <= S_FIN_RD;
				end
				// read the head for the largest free size
				S_FIN_RD: state_q <= S_FIN;
				S_FIN: begin
					largest_q <= (count_q == '0) ? '0 : LEN_W'(rd_size);
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign status          = stat_q;
	assign granted_address = grant_q;
	assign largest_free    = largest_q;

endmodule
`default_nettype wire

### rtl/cea_checker.sv
// port-level checker for the extent allocator, with its bind
`timescale 1ns / 1ps
`default_nettype none
module cea_checker import cea_pkg::*; (
	input wire               clk,
	input wire               arst_n,
	input wire               valid,
	input wire               ready,
	input wire               out_valid,
	input wire               out_ready,
	input wire [STAT_W-1:0]  status,
	input wire [ADDR_W-1:0]  granted_address
);
	// a result word holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result word changed while stalled");
	// no new request while a result waits
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !ready)
		else $error("ready while result pending");
	// status codes stay in range
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("bad status");
	// failed requests grant nothing
	a_grant: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> granted_address == '0)
		else $error("grant on failure");
endmodule

bind coalescing_extent_allocator cea_checker u_cea_checker (
	.clk(clk), .arst_n(arst_n), .valid(valid), .ready(ready),
	.out_valid(out_valid), .out_ready(out_ready), .status(status),
	.granted_address(granted_address)
);
`default_nettype wire
